FILE: hdl/wrl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrl_pkg
// Types and constants shared by the wheel report link modules.
// ----------------------------------------------------------------------------
package wrl_pkg;

    // event codes carried in the mode field
    typedef enum logic [3:0] {
        EV_RESTART     = 4'd0,
        EV_CLOSE       = 4'd1,
        EV_POWER_ON    = 4'd2,
        EV_POWER_OFF   = 4'd3,
        EV_CHECK_BEGIN = 4'd4,
        EV_CHECK_END   = 4'd5,
        EV_CHECK_PWR   = 4'd6,
        EV_RESYNC      = 4'd7,
        EV_POLL        = 4'd8
    } t_event;

    typedef enum logic [2:0] {
        LS_CLOSED   = 3'd0,
        LS_IDLE     = 3'd1,
        LS_POWERING = 3'd2,
        LS_CHECKING = 3'd3,
        LS_RUNNING  = 3'd4
    } t_link_state;

    // configuration register indexes
    localparam logic [1:0] CFG_UNPROMPTED = 2'd0;
    localparam logic [1:0] CFG_VOLUNTEERS = 2'd1;
    localparam logic [1:0] CFG_PERIOD     = 2'd2;

    localparam logic [7:0] PERIOD_RESET = 8'd4;

    localparam logic [7:0] CHAR_C    = 8'h43;
    localparam logic [7:0] CHAR_H    = 8'h48;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_ONE  = 8'h31;

    typedef struct packed {
        logic       unprompted;
        logic       volunteers;
        logic [7:0] period;
    } t_cfg;

    typedef struct packed {
        t_link_state link_state;
        logic [7:0]  byte2;
        logic [7:0]  byte1;
        logic [7:0]  byte0;
        logic        valid;
    } t_result;

endpackage

FILE: hdl/wrl_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrl_engine
// Link state register, pending power report flag and next report time, with
// the combinational event logic that updates them and forms the result.
// ----------------------------------------------------------------------------
module wrl_engine #(
    parameter int TIME_WIDTH = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  wrl_pkg::t_cfg         i_cfg,
    input  logic [3:0]            i_mode,
    input  logic [TIME_WIDTH-1:0] i_now,
    input  logic [15:0]           i_pos,
    output wrl_pkg::t_result      o_result
);

    wrl_pkg::t_link_state  r_board_mode, n_board_mode;
    logic                  r_pending, n_pending;
    logic [TIME_WIDTH-1:0] r_next_time, n_next_time;

    logic [TIME_WIDTH:0]   w_sum;
    logic [TIME_WIDTH-1:0] w_due;
    logic                  w_early;

    // now + period, saturating at the top of the time range
    assign w_sum   = {1'b0, i_now} + (TIME_WIDTH + 1)'(i_cfg.period);
    assign w_due   = w_sum[TIME_WIDTH] ? '1 : w_sum[TIME_WIDTH-1:0];
    assign w_early = (r_next_time != '0) && (i_now < r_next_time);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_mode <= wrl_pkg::LS_CLOSED;
            r_pending    <= 1'b0;
            r_next_time  <= '0;
        end else if (i_fire) begin
            r_board_mode <= n_board_mode;
            r_pending    <= n_pending;
            r_next_time  <= n_next_time;
        end
    end

    always_comb begin
        n_board_mode = r_board_mode;
        n_pending    = r_pending;
        n_next_time  = r_next_time;
        o_result     = '0;

        case (wrl_pkg::t_event'(i_mode))
            wrl_pkg::EV_RESTART: begin
                n_pending    = i_cfg.unprompted & i_cfg.volunteers;
                n_next_time  = '0;
                n_board_mode = wrl_pkg::LS_IDLE;
            end
            wrl_pkg::EV_CLOSE: begin
                n_pending    = 1'b0;
                n_next_time  = '0;
                n_board_mode = wrl_pkg::LS_CLOSED;
            end
            wrl_pkg::EV_POWER_ON: begin
                n_pending    = 1'b0;
                n_next_time  = '0;
                n_board_mode = wrl_pkg::LS_POWERING;
            end
            wrl_pkg::EV_POWER_OFF: begin
                n_pending    = 1'b0;
                n_next_time  = '0;
                n_board_mode = wrl_pkg::LS_IDLE;
            end
            wrl_pkg::EV_CHECK_BEGIN: begin
                n_pending    = 1'b0;
                n_next_time  = '0;
                n_board_mode = wrl_pkg::LS_CHECKING;
            end
            wrl_pkg::EV_CHECK_END: begin
                if (r_board_mode == wrl_pkg::LS_CHECKING) begin
                    n_board_mode = wrl_pkg::LS_RUNNING;
                    n_next_time  = '0;
                end
            end
            wrl_pkg::EV_CHECK_PWR: begin
                n_pending    = 1'b0;
                n_next_time  = '0;
                n_board_mode = wrl_pkg::LS_RUNNING;
            end
            wrl_pkg::EV_RESYNC: begin
                if (r_board_mode == wrl_pkg::LS_RUNNING ||
                    r_board_mode == wrl_pkg::LS_POWERING) begin
                    n_next_time = i_now;
                end
            end
            wrl_pkg::EV_POLL: begin
                if (!i_cfg.unprompted || r_board_mode == wrl_pkg::LS_CLOSED) begin
                    n_pending = r_pending;
                end else if (r_pending) begin
                    // motor-running report goes out ahead of any wheel report
                    o_result.valid = 1'b1;
                    o_result.byte0 = wrl_pkg::CHAR_C;
                    o_result.byte1 = wrl_pkg::CHAR_ZERO;
                    o_result.byte2 = wrl_pkg::CHAR_ONE;
                    n_pending      = 1'b0;
                    n_board_mode   = wrl_pkg::LS_POWERING;
                    n_next_time    = w_due;
                end else if (r_board_mode != wrl_pkg::LS_IDLE &&
                             r_board_mode != wrl_pkg::LS_CHECKING && !w_early) begin
                    o_result.valid = 1'b1;
                    o_result.byte0 = wrl_pkg::CHAR_H;
                    o_result.byte1 = i_pos[15:8];
                    o_result.byte2 = i_pos[7:0];
                    n_next_time    = w_due;
                end
            end
            default: begin
                n_board_mode = r_board_mode;
            end
        endcase

        o_result.link_state = n_board_mode;
    end

endmodule

FILE: hdl/wheel_report_link_state_machine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_report_link_state_machine
// Steering sensor board link: one event in, one result out.
// ----------------------------------------------------------------------------
// Takes one event per clock while the result stream does not stall, and
// returns exactly one result per event, in order. An event is held in an input
// register, applied to the link state, and its result lands in an output
// register, so each event passes the input register and then the output
// register before its output transaction; throughput is one event per cycle
// unless the result stream stalls. The limit is the update of the state register
// that every event reads. The output register lets a new event be taken while a result waits.
// Configuration writes are meant to be made with no event in flight.
// ----------------------------------------------------------------------------
module wheel_report_link_state_machine #(
    parameter  int TIME_WIDTH = 48,
    localparam int S_TDATA_W  = ((20 + TIME_WIDTH + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // event stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // mode[3:0], now_ms[TIME_WIDTH-1:0], wheel_position[15:0], zero fill
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // report_valid, report_byte0, report_byte1, report_byte2, link_state[2:0],
    // zero fill
    output logic [31:0]          m_axis_tdata,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    wrl_pkg::t_cfg         r_cfg;
    logic                  r_in_valid;
    logic [3:0]            r_in_mode;
    logic [TIME_WIDTH-1:0] r_in_now;
    logic [15:0]           r_in_pos;
    logic                  r_out_valid;
    wrl_pkg::t_result      r_out;
    wrl_pkg::t_result      w_result;
    logic                  w_advance;
    logic                  w_fire;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.unprompted <= 1'b0;
            r_cfg.volunteers <= 1'b0;
            r_cfg.period     <= wrl_pkg::PERIOD_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                wrl_pkg::CFG_UNPROMPTED: r_cfg.unprompted <= i_cfg_data[0];
                wrl_pkg::CFG_VOLUNTEERS: r_cfg.volunteers <= i_cfg_data[0];
                wrl_pkg::CFG_PERIOD:     r_cfg.period     <= i_cfg_data;
                default:                 r_cfg            <= r_cfg;
            endcase
        end
    end

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_mode <= s_axis_tdata[3:0];
            r_in_now  <= s_axis_tdata[4 +: TIME_WIDTH];
            r_in_pos  <= s_axis_tdata[4 + TIME_WIDTH +: 16];
        end
    end

    wrl_engine #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_cfg    (r_cfg),
        .i_mode   (r_in_mode),
        .i_now    (r_in_now),
        .i_pos    (r_in_pos),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out};

    // a report only leaves from powering on or running
    a_report_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.valid) |->
            (r_out.link_state == wrl_pkg::LS_POWERING ||
             r_out.link_state == wrl_pkg::LS_RUNNING))
        else $error("report with link not powering or running");

    // report bytes are zero unless a report was made, and byte0 is C or H otherwise
    a_report_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |->
            (r_out.valid ? (r_out.byte0 == wrl_pkg::CHAR_C ||
                            r_out.byte0 == wrl_pkg::CHAR_H)
                         : (r_out.byte0 == 8'd0 && r_out.byte1 == 8'd0 &&
                            r_out.byte2 == 8'd0)))
        else $error("malformed report bytes");

    // a held event moves to the output register when that register is free
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> r_out_valid)
        else $error("held event did not reach output register");

endmodule

FILE: dv/tb_wheel_report_link_state_machine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wheel_report_link_state_machine
// Self-checking testbench for the steering sensor board link. A behavioral
// predictor tracks link mode, pending power report and next wheel report time;
// every event transaction queues one expected result, and a checker compares
// each output transaction field by field. Directed cases come first, followed
// by random event traffic over several register settings and random idling on
// both streams, then random events against a long result hold-off.
// ----------------------------------------------------------------------------
module tb_wheel_report_link_state_machine;

    localparam int TW = 48;
    localparam int S_W = ((20 + TW + 7) / 8) * 8;
    localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};
    localparam logic [TW-1:0] T0 = 48'h0000_1234_5678;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_CYCLES = 200;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [S_W-1:0] s_axis_tdata;
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [31:0]    m_axis_tdata;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [1:0]     i_cfg_index;
    logic [7:0]     i_cfg_data;

    // predictor state and register copies
    logic                 cfg_unprompted = 1'b0;
    logic                 cfg_volunteers = 1'b0;
    logic [7:0]           cfg_period = wrl_pkg::PERIOD_RESET;
    wrl_pkg::t_link_state link_mode = wrl_pkg::LS_CLOSED;
    logic                 power_armed = 1'b0;
    logic [TW-1:0]        next_due_ms = '0;

    wrl_pkg::t_result expected_results[$];
    logic [TW-1:0]  sim_ms = '0;
    int             hold_request = 0;
    bit             src_idles = 1'b1;
    bit             sink_stalls = 1'b1;
    int             idle_cycles = 0;
    int             n_errors = 0;
    int             n_events = 0;
    int             n_cfg_writes = 0;
    int             n_c_reports = 0;
    int             n_h_reports = 0;
    int             n_silent = 0;

    wheel_report_link_state_machine #(.TIME_WIDTH(TW)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic [TW-1:0] report_due(input logic [TW-1:0] now);
        if (now > TIME_MAX - TW'(cfg_period)) return TIME_MAX;
        return now + TW'(cfg_period);
    endfunction

    function automatic void enter_mode(input wrl_pkg::t_link_state m);
        power_armed = 1'b0;
        next_due_ms = '0;
        link_mode   = m;
    endfunction

    function automatic wrl_pkg::t_result step_link(input logic [3:0] mode,
                                                   input logic [TW-1:0] now,
                                                   input logic [15:0] pos);
        wrl_pkg::t_result r;
        r = '0;
        case (mode)
            wrl_pkg::EV_RESTART: begin
                power_armed = cfg_unprompted & cfg_volunteers;
                next_due_ms = '0;
                link_mode   = wrl_pkg::LS_IDLE;
            end
            wrl_pkg::EV_CLOSE:       enter_mode(wrl_pkg::LS_CLOSED);
            wrl_pkg::EV_POWER_ON:    enter_mode(wrl_pkg::LS_POWERING);
            wrl_pkg::EV_POWER_OFF:   enter_mode(wrl_pkg::LS_IDLE);
            wrl_pkg::EV_CHECK_BEGIN: enter_mode(wrl_pkg::LS_CHECKING);
            wrl_pkg::EV_CHECK_PWR:   enter_mode(wrl_pkg::LS_RUNNING);
            wrl_pkg::EV_CHECK_END: begin
                if (link_mode == wrl_pkg::LS_CHECKING) begin
                    link_mode   = wrl_pkg::LS_RUNNING;
                    next_due_ms = '0;
                end
            end
            wrl_pkg::EV_RESYNC: begin
                if (link_mode == wrl_pkg::LS_RUNNING || link_mode == wrl_pkg::LS_POWERING)
                    next_due_ms = now;
            end
            wrl_pkg::EV_POLL: begin
                if (cfg_unprompted && link_mode != wrl_pkg::LS_CLOSED) begin
                    if (power_armed) begin
                        r.valid     = 1'b1;
                        r.byte0     = wrl_pkg::CHAR_C;
                        r.byte1     = wrl_pkg::CHAR_ZERO;
                        r.byte2     = wrl_pkg::CHAR_ONE;
                        power_armed = 1'b0;
                        link_mode   = wrl_pkg::LS_POWERING;
                        next_due_ms = report_due(now);
                    end else if (link_mode != wrl_pkg::LS_IDLE &&
                                 link_mode != wrl_pkg::LS_CHECKING &&
                                 !(next_due_ms != '0 && now < next_due_ms)) begin
                        r.valid     = 1'b1;
                        r.byte0     = wrl_pkg::CHAR_H;
                        r.byte1     = pos[15:8];
                        r.byte2     = pos[7:0];
                        next_due_ms = report_due(now);
                    end
                end
            end
            default: ;  // unknown codes leave everything as is
        endcase
        r.link_state = link_mode;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    // called at a falling edge; returns at a falling edge
    task automatic send_event(input logic [3:0] mode, input logic [TW-1:0] now,
                              input logic [15:0] pos);
        int gap;
        s_axis_tdata  <= {4'b0000, pos, now, mode};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_results.push_back(step_link(mode, now, pos));
        n_events++;
        @(negedge i_clk);
        gap = src_idles ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic poll(input logic [TW-1:0] now, input logic [15:0] pos);
        send_event(wrl_pkg::EV_POLL, now, pos);
    endtask

    // wait until the block holds no event, so registers may change
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            wrl_pkg::CFG_UNPROMPTED: cfg_unprompted = val[0];
            wrl_pkg::CFG_VOLUNTEERS: cfg_volunteers = val[0];
            wrl_pkg::CFG_PERIOD:     cfg_period = val;
            default: ;
        endcase
        n_cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [3:0] pick_mode();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 48) return wrl_pkg::EV_POLL;
        if (r < 56) return wrl_pkg::EV_RESYNC;
        if (r < 64) return wrl_pkg::EV_RESTART;
        if (r < 70) return wrl_pkg::EV_POWER_ON;
        if (r < 75) return wrl_pkg::EV_CHECK_PWR;
        if (r < 80) return wrl_pkg::EV_CHECK_BEGIN;
        if (r < 86) return wrl_pkg::EV_CHECK_END;
        if (r < 91) return wrl_pkg::EV_POWER_OFF;
        if (r < 96) return wrl_pkg::EV_CLOSE;
        return 4'($urandom_range(9, 15));
    endfunction

    function automatic logic [TW-1:0] next_time(input logic [TW-1:0] t);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return t + TW'($urandom_range(0, 2 * cfg_period + 2));
        if (r < 82) return t;
        if (r < 94) return {16'($urandom), 32'($urandom)};
        return TIME_MAX - TW'($urandom_range(0, 600));
    endfunction

    task automatic run_random_events(input int n);
        int         counted;
        logic [3:0] mode;
        counted = 0;
        while (counted < n) begin
            mode   = pick_mode();
            sim_ms = next_time(sim_ms);
            send_event(mode, sim_ms, 16'($urandom));
            if (mode <= wrl_pkg::EV_POLL) counted++;
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset settings: polls never report
    task automatic test_quiet_link();
        poll(T0, 16'hFFFF);
        send_event(wrl_pkg::EV_RESTART, '0, '0);
        poll('0, 16'h1234);
        send_event(wrl_pkg::EV_POWER_ON, TIME_MAX, 16'hFFFF);
        poll(TIME_MAX, 16'hFFFF);
        send_event(4'd9, T0, 16'h5555);
        send_event(4'd15, TIME_MAX, 16'hFFFF);
        drain_results();
    endtask

    task automatic test_power_report();
        write_reg(wrl_pkg::CFG_UNPROMPTED, 8'h01);
        write_reg(wrl_pkg::CFG_VOLUNTEERS, 8'h01);
        write_reg(wrl_pkg::CFG_PERIOD, wrl_pkg::PERIOD_RESET);
        send_event(wrl_pkg::EV_RESTART, '0, '0);
        poll(T0, 16'hA5C3);              // motor-running report first
        poll(T0 + 3, 16'h0001);          // not yet due
        poll(T0 + 4, 16'hFFFF);
        send_event(wrl_pkg::EV_RESYNC, '0, '0);   // zero means due now
        poll('0, 16'h0000);
        send_event(wrl_pkg::EV_CHECK_BEGIN, T0, '0);
        poll(T0, 16'h1111);              // silent while checking
        send_event(wrl_pkg::EV_CHECK_END, T0, '0);
        poll(T0, 16'h8001);
        send_event(wrl_pkg::EV_CHECK_END, T0, '0);  // ignored outside self check
        send_event(wrl_pkg::EV_RESYNC, T0, '0);
        send_event(wrl_pkg::EV_POWER_OFF, T0, '0);
        send_event(wrl_pkg::EV_RESYNC, T0, '0);     // ignored in idle
        poll(T0, 16'h2222);
        send_event(wrl_pkg::EV_CLOSE, T0, '0);
        poll(T0, 16'h3333);
        drain_results();
    endtask

    task automatic test_time_edges();
        write_reg(wrl_pkg::CFG_PERIOD, 8'hFF);
        send_event(wrl_pkg::EV_CHECK_PWR, '0, '0);
        poll(TIME_MAX, 16'h7FFE);        // due time saturates
        poll(TIME_MAX - 1, 16'h0F0F);
        poll(TIME_MAX, 16'hF0F0);
        drain_results();
        write_reg(wrl_pkg::CFG_PERIOD, 8'h00);
        poll(T0, 16'h0102);
        poll(T0, 16'h0304);
        drain_results();
    endtask

    task automatic test_reg_writes();
        write_reg(CFG_UNUSED, 8'hFF);     // no such register
        write_reg(wrl_pkg::CFG_UNPROMPTED, 8'hFE); // only bit 0 counts
        poll(T0, 16'h4444);
        drain_results();
        write_reg(wrl_pkg::CFG_UNPROMPTED, 8'h01);
        write_reg(wrl_pkg::CFG_VOLUNTEERS, 8'h00);
        send_event(wrl_pkg::EV_RESTART, T0, '0);   // no power report armed
        poll(T0, 16'h5555);
        drain_results();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(wrl_pkg::CFG_UNPROMPTED, 8'h01);
                    write_reg(wrl_pkg::CFG_PERIOD, 8'h01);
                end
                1:       write_reg(wrl_pkg::CFG_PERIOD, 8'hFF);
                2:       write_reg(wrl_pkg::CFG_UNPROMPTED, 8'h00);
                default: begin
                    write_reg(wrl_pkg::CFG_UNPROMPTED,
                              {7'($urandom), 1'($urandom_range(0, 3) != 0)});
                    write_reg(wrl_pkg::CFG_PERIOD, 8'($urandom));
                end
            endcase
            write_reg(wrl_pkg::CFG_VOLUNTEERS, 8'($urandom));
            src_idles   = (phase % 4 != 0);
            sink_stalls = (phase % 4 != 0);
            run_random_events(60);
            drain_results();
        end
        src_idles   = 1'b1;
        sink_stalls = 1'b1;
    endtask

    // sink holds off while the source keeps offering, so the block backs up
    task automatic test_backpressure();
        write_reg(wrl_pkg::CFG_UNPROMPTED, 8'h01);
        write_reg(wrl_pkg::CFG_VOLUNTEERS, 8'h01);
        write_reg(wrl_pkg::CFG_PERIOD, 8'h02);
        src_idles    = 1'b0;
        hold_request = HOLD_CYCLES;
        send_event(wrl_pkg::EV_RESTART, sim_ms, '0);
        run_random_events(24);
        drain_results();
        src_idles = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string msg);
        $display("%0t: MISMATCH %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got 0x%02h want 0x%02h", name, got, want));
    endtask

    always @(posedge i_clk) begin
        wrl_pkg::t_result got;
        wrl_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = wrl_pkg::t_result'(m_axis_tdata[27:0]);
            if (expected_results.size() == 0) begin
                flag_mismatch($sformatf("result 0x%08h with nothing expected", m_axis_tdata));
            end else begin
                want = expected_results.pop_front();
                check_field("report_valid", 8'(got.valid), 8'(want.valid));
                check_field("report_byte0", got.byte0, want.byte0);
                check_field("report_byte1", got.byte1, want.byte1);
                check_field("report_byte2", got.byte2, want.byte2);
                check_field("link_state", 8'(got.link_state), 8'(want.link_state));
                if (want.valid && want.byte0 == wrl_pkg::CHAR_C) n_c_reports++;
                else if (want.valid) n_h_reports++;
                else n_silent++;
            end
        end
    end

    // result sink with random stalls and the long hold-off
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_request) @(negedge i_clk);
                hold_request = 0;
            end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat (pick_gap() + 1) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog: cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, expected_results.size());
            $display("tb_wheel_report_link_state_machine NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = wrl_pkg::CFG_UNPROMPTED;
        i_cfg_data    = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_quiet_link();
        test_power_report();
        test_time_edges();
        test_reg_writes();
        test_random_traffic();
        test_backpressure();

        drain_results();
        repeat (10) @(negedge i_clk);
        $display("covered %0d events and %0d register writes over several settings",
                 n_events, n_cfg_writes);
        $display("results: %0d motor-running reports, %0d wheel reports, %0d without report",
                 n_c_reports, n_h_reports, n_silent);
        if (n_errors == 0) begin
            $display("tb_wheel_report_link_state_machine OK");
        end else begin
            $display("tb_wheel_report_link_state_machine NOT OK");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/wrl_pkg.sv
hdl/wrl_engine.sv
hdl/wheel_report_link_state_machine.sv
dv/tb_wheel_report_link_state_machine.sv
